// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define PLE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define PLE_NEVER(label, clk, rst_n, cond, msg) \
	`PLE_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// File: hdl/ple_pkg.sv
// Types and codes shared by the positional list engine modules.
`timescale 1ns / 1ps

package ple_pkg;

	typedef enum logic [2:0] {
		OP_INS_FIRST = 3'd0,
		OP_INS_LAST  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FIRST = 3'd3,
		OP_DEL_LAST  = 3'd4,
		OP_DEL_POS   = 3'd5,
		OP_LIST      = 3'd6,
		OP_COUNT     = 3'd7
	} ple_op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} ple_status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_LIST = 1'b1
	} ple_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;  // take the input word, apply the edit
		logic step;  // emit the head entry and rotate the chain
	} ple_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;    // output register can take a word this cycle
		logic list_start;  // input word is a list of a non-empty list
		logic rem_last;    // one entry left to stream
	} ple_stat_t;

endpackage

// File: hdl/ple_ctrl.sv
// Controller state machine of the positional list engine.
`timescale 1ns / 1ps

module ple_ctrl
	import ple_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  ple_stat_t stat,
	output ple_cmd_t  cmd,
	output logic      in_ready
);

	ple_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && stat.out_free && stat.list_start) begin
					state_nxt = S_LIST;
				end
			end
			S_LIST: begin
				if (stat.out_free && stat.rem_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = stat.out_free;
				cmd.load = in_valid && stat.out_free;
			end
			S_LIST: begin
				cmd.step = stat.out_free;
			end
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: hdl/ple_dpath.sv
// Datapath of the positional list engine: chain of entry cells, count, output register.
`timescale 1ns / 1ps

module ple_dpath
	import ple_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ple_cmd_t                           cmd,
	output ple_stat_t                          stat,
	input  logic [2:0]                         op,
	input  logic signed [31:0]                 value,
	input  logic [7:0]                         position,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [31:0]                 item_value,
	output logic                               has_value,
	output logic [$clog2(CAPACITY+1)-1:0]      entry_count,
	output logic [1:0]                         status,
	output logic                               last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = ((CW > 8) ? CW : 8) + 1;

	logic [31:0]   cell_q [CAPACITY];
	logic [CW-1:0] count_q, cnt_nxt, rem_q;
	logic          out_valid_q;

	logic signed [31:0] item_value_q;
	logic               has_value_q;
	logic [CW-1:0]      entry_count_q;
	logic [1:0]         status_q;
	logic               last_q;

	ple_op_t       op_e;
	ple_status_t   st;
	logic          edit_ins, edit_del;
	logic [IW-1:0] edit_idx, rot_end;
	logic [PW-1:0] pos_w, cnt_w;
	logic          full, empty;

	assign op_e    = ple_op_t'(op);
	assign pos_w   = PW'(position);
	assign cnt_w   = PW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));
	assign empty   = (count_q == '0);
	assign rot_end = IW'(count_q - CW'(1));

	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.list_start = (op_e == OP_LIST) && !empty;
	assign stat.rem_last   = (rem_q == CW'(1));

	always_comb begin
		edit_ins = 1'b0;
		edit_del = 1'b0;
		edit_idx = '0;
		st       = ST_OK;
		cnt_nxt  = count_q;
		unique case (op_e)
			OP_INS_FIRST, OP_INS_LAST, OP_INS_POS: begin
				if (full) begin
					st = ST_FULL;
				end else if (op_e == OP_INS_POS &&
					(pos_w == '0 || pos_w > cnt_w + PW'(1))) begin
					st = ST_BADPOS;
				end else begin
					edit_ins = 1'b1;
					cnt_nxt  = count_q + CW'(1);
					priority if (op_e == OP_INS_FIRST) begin
						edit_idx = '0;
					end else if (op_e == OP_INS_LAST) begin
						edit_idx = IW'(count_q);
					end else begin
						edit_idx = IW'(pos_w - PW'(1));
					end
				end
			end
			OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_POS: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (op_e == OP_DEL_POS && (pos_w == '0 || pos_w > cnt_w)) begin
					st = ST_BADPOS;
				end else begin
					edit_del = 1'b1;
					cnt_nxt  = count_q - CW'(1);
					priority if (op_e == OP_DEL_FIRST) begin
						edit_idx = '0;
					end else if (op_e == OP_DEL_LAST) begin
						edit_idx = rot_end;
					end else begin
						edit_idx = IW'(pos_w - PW'(1));
					end
				end
			end
			OP_LIST, OP_COUNT: begin
				st = ST_OK;
			end
			default: st = ST_OK;
		endcase
	end

	// each cell sees only its neighbors and the head
	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		logic [31:0] prv, nxt;
		if (gi == 0) begin : g_head
			assign prv = cell_q[0];
		end else begin : g_body
			assign prv = cell_q[gi-1];
		end
		if (gi == CAPACITY - 1) begin : g_tail
			assign nxt = cell_q[gi];
		end else begin : g_inner
			assign nxt = cell_q[gi+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.load && edit_ins) begin
				if (IW'(gi) == edit_idx) begin
					cell_q[gi] <= value;
				end else if (IW'(gi) > edit_idx) begin
					cell_q[gi] <= prv;
				end
			end else if (cmd.load && edit_del) begin
				if (IW'(gi) >= edit_idx) begin
					cell_q[gi] <= nxt;
				end
			end else if (cmd.step) begin
				if (IW'(gi) == rot_end) begin
					cell_q[gi] <= cell_q[0];
				end else if (IW'(gi) < rot_end) begin
					cell_q[gi] <= nxt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= cnt_nxt;
			end
			if (cmd.load && stat.list_start) begin
				rem_q <= count_q;
			end else if (cmd.step) begin
				rem_q <= rem_q - CW'(1);
			end
			if ((cmd.load && !stat.list_start) || cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !stat.list_start) begin
			item_value_q  <= '0;
			has_value_q   <= 1'b0;
			entry_count_q <= cnt_nxt;
			status_q      <= st;
			last_q        <= 1'b1;
		end else if (cmd.step) begin
			item_value_q  <= cell_q[0];
			has_value_q   <= 1'b1;
			entry_count_q <= count_q;
			status_q      <= ST_OK;
			last_q        <= stat.rem_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign item_value  = item_value_q;
	assign has_value   = has_value_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule

// File: hdl/positional_list_engine_unit.sv
// Top level of the positional list engine: ordered list of signed words with positional edits.
//
//   channel | words                              | handshake
//   in      | op, value, position                | in_valid / in_ready
//   out     | item_value, has_value, entry_count,| out_valid / out_ready
//           | status, last                       |
//
// Edits, count and errors give one registered result word per input word.
// List streams one entry per cycle, while out_ready allows, from the head of the cell chain,
// which rotates back into order once every entry has streamed; input is held off meanwhile.
// A single output register separates the sides; a new word is taken while
// the previous result is being taken. Stalls on out_ready stall everything.
// Reset clears the count and control; cell contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module positional_list_engine_unit
	import ple_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    op,
	input  logic signed [31:0]            value,
	input  logic [7:0]                    position,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            item_value,
	output logic                          has_value,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count,
	output logic [1:0]                    status,
	output logic                          last
);

	ple_cmd_t  cmd;
	ple_stat_t stat;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	ple_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.value       (value),
		.position    (position),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.item_value  (item_value),
		.has_value   (has_value),
		.entry_count (entry_count),
		.status      (status),
		.last        (last)
	);

	`PLE_ASSERT(a_ready_needs_room, clk, arst_n, in_ready |-> (!out_valid || out_ready), "in_ready while output word blocked")
	`PLE_NEVER(a_count_bound, clk, arst_n, out_valid && (entry_count > ($clog2(CAPACITY+1))'(CAPACITY)), "entry_count above capacity")
	`PLE_ASSERT(a_entry_ok, clk, arst_n, (out_valid && has_value) |-> (status == ST_OK), "list word with error status")
	`PLE_ASSERT(a_single_last, clk, arst_n, (out_valid && !has_value) |-> last, "non-list word without last")

endmodule
